[rtl/bcp_pkg.sv]
// bcp_pkg: shared types and constants for the binomial call pricer
// sequencer states, register indexes, status codes and Q2.30 constants
// no dependencies
`default_nettype none

package bcp_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK,
      S_PDIV,
      S_DNM,
      S_DNR,
      S_PAY,
      S_UPM,
      S_UCHK,
      S_UDIV,
      S_IRD,
      S_IM1,
      S_IM2,
      S_IM3,
      S_IWB,
      S_DONE
   } state_type;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_INVALID = 2'd1;
   localparam status_type STATUS_SAT     = 2'd2;

   localparam logic [2:0] REG_UP     = 3'd0;
   localparam logic [2:0] REG_DOWN   = 3'd1;
   localparam logic [2:0] REG_GROWTH = 3'd2;
   localparam logic [2:0] REG_DISC   = 3'd3;
   localparam logic [2:0] REG_PERIOD = 3'd4;

   localparam logic [31:0] UP_RESET     = 32'd1181116006;
   localparam logic [31:0] DOWN_RESET   = 32'd966367641;
   localparam logic [31:0] GROWTH_RESET = 32'd1084479242;
   localparam logic [31:0] DISC_RESET   = 32'd1063110717;
   localparam logic [6:0]  PERIOD_RESET = 7'd64;

   localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
   localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;

endpackage

`default_nettype wire

[rtl/binomial_call_pricer.sv]
// binomial_call_pricer: european call on a recombining binomial tree
// node values live in one synchronous ram; one shared divider serves both divides
// depends on bcp_pkg
//
// req channel: one beat carries spot and strike (q16.16); rsp channel returns
// one beat with the call value and a status (ok, invalid factors, saturated).
// csr port: up, down, growth, discount (q2.30) and period count; these must be
// written only while the block is idle; the block does not enforce this.
// one request is worked at a time. a request runs the divider for the up
// probability, a multiply and a rounding per down step, a multiply, an
// overflow check and a restoring divide per up node, and per backward
// induction node a read, a multiply and a multiply-accumulate, a discount
// multiply and a write-back on the single ram port pair. invalid factors go
// straight to the done state.
// the result sits in an output register and is held while rsp_tready is low;
// the next request is still taken and worked, and its result waits in the
// done state until the held beat leaves. reset restores the register
// defaults, empties the output register and returns to idle; the ram needs
// no clearing.
`default_nettype none

module binomial_call_pricer #(
   parameter int MAX_PERIODS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // spot_price[31:0], strike_price[63:32]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // call_value[31:0], status[33:32], zero fill
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [31:0] csr_wdata
);

   localparam int NW = $clog2(MAX_PERIODS + 1);

   bcp_pkg::state_type state_ff, state_in;

   logic [31:0] up_ff, down_ff, growth_ff, disc_ff;
   logic [6:0]  pc_ff;

   logic [31:0] spot_ff, spot_in, strike_ff, strike_in;
   logic [NW-1:0] n_ff, n_in, i_ff, i_in, step_ff, step_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] div_ff, div_in, rem_ff, rem_in, lo_ff, lo_in;
   logic [30:0] p_ff, p_in;
   logic [31:0] price_ff, price_in;
   logic [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [31:0] cur_ff, cur_in, nxt_ff, nxt_in, w0_ff, w0_in;
   logic        sat_ff, sat_in, inv_ff, inv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   bcp_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [31:0] mem [MAX_PERIODS+1];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [NW-1:0] mem_waddr, mem_raddr;
   logic [31:0] mem_wdata;

   logic        invalid;
   logic [31:0] gd;
   logic [32:0] dv_t;
   logic        dv_ge;
   logic [31:0] dv_rem, dv_lo;
   logic [34:0] rnd_sum;
   logic        rnd_ovf;
   logic [31:0] rnd_val;
   logic        mix_ovf;
   logic [31:0] mix_val;
   logic [31:0] payoff;
   logic [30:0] q_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff     <= bcp_pkg::UP_RESET;
         down_ff   <= bcp_pkg::DOWN_RESET;
         growth_ff <= bcp_pkg::GROWTH_RESET;
         disc_ff   <= bcp_pkg::DISC_RESET;
         pc_ff     <= bcp_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            bcp_pkg::REG_UP:     up_ff     <= csr_wdata;
            bcp_pkg::REG_DOWN:   down_ff   <= csr_wdata;
            bcp_pkg::REG_GROWTH: growth_ff <= csr_wdata;
            bcp_pkg::REG_DISC:   disc_ff   <= csr_wdata;
            bcp_pkg::REG_PERIOD: pc_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // node value ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      invalid = (down_ff == 32'd0) || (up_ff <= down_ff) ||
                (growth_ff < down_ff) || (growth_ff > up_ff);
      gd      = growth_ff - down_ff;
      dv_t    = {rem_ff, lo_ff[31]};
      dv_ge   = dv_t >= {1'b0, div_ff};
      dv_rem  = dv_ge ? 32'(dv_t - {1'b0, div_ff}) : dv_t[31:0];
      dv_lo   = {lo_ff[30:0], dv_ge};
      rnd_sum = {1'b0, prod_ff[63:30]} + 35'(prod_ff[29]);
      rnd_ovf = |rnd_sum[34:32];
      rnd_val = rnd_ovf ? 32'hFFFF_FFFF : rnd_sum[31:0];
      mix_ovf = |acc_ff[63:62];
      mix_val = mix_ovf ? 32'hFFFF_FFFF : acc_ff[61:30];
      payoff  = (price_ff > strike_ff) ? price_ff - strike_ff : 32'd0;
      q_val   = bcp_pkg::Q30_ONE - p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      spot_ff       <= spot_in;
      strike_ff     <= strike_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      lo_ff         <= lo_in;
      p_ff          <= p_in;
      price_ff      <= price_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      w0_ff         <= w0_in;
      sat_ff        <= sat_in;
      inv_ff        <= inv_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      spot_in       = spot_ff;
      strike_in     = strike_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      lo_in         = lo_ff;
      p_in          = p_ff;
      price_in      = price_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      w0_in         = w0_ff;
      sat_in        = sat_ff;
      inv_in        = inv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      req_tready    = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = i_ff;
      mem_wdata     = payoff;
      mem_raddr     = NW'(i_ff + 1'b1);

      case (state_ff)
         bcp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               spot_in   = req_tdata[31:0];
               strike_in = req_tdata[63:32];
               n_in      = (32'(pc_ff) > 32'(MAX_PERIODS)) ? NW'(MAX_PERIODS) : NW'(pc_ff);
               sat_in    = 1'b0;
               inv_in    = 1'b0;
               state_in  = bcp_pkg::S_CHK;
            end
         end
         bcp_pkg::S_CHK: begin
            if (invalid) begin
               inv_in   = 1'b1;
               w0_in    = 32'd0;
               state_in = bcp_pkg::S_DONE;
            end else begin
               div_in   = up_ff - down_ff;
               rem_in   = {2'b00, gd[31:2]};
               lo_in    = {gd[1:0], 30'd0};
               cnt_in   = 5'd0;
               state_in = bcp_pkg::S_PDIV;
            end
         end
         bcp_pkg::S_PDIV: begin
            rem_in = dv_rem;
            lo_in  = dv_lo;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               p_in     = dv_lo[30:0];
               price_in = spot_ff;
               i_in     = '0;
               state_in = (n_ff == '0) ? bcp_pkg::S_PAY : bcp_pkg::S_DNM;
            end
         end
         bcp_pkg::S_DNM: begin
            prod_in  = 64'(price_ff) * 64'(down_ff);
            state_in = bcp_pkg::S_DNR;
         end
         bcp_pkg::S_DNR: begin
            price_in = rnd_val;
            sat_in   = sat_ff | rnd_ovf;
            if (NW'(i_ff + 1'b1) == n_ff) begin
               i_in     = '0;
               state_in = bcp_pkg::S_PAY;
            end else begin
               i_in     = NW'(i_ff + 1'b1);
               state_in = bcp_pkg::S_DNM;
            end
         end
         bcp_pkg::S_PAY: begin
            mem_we = 1'b1;
            if (i_ff == '0) begin
               w0_in = payoff;
            end
            if (i_ff == n_ff) begin
               if (n_ff == '0) begin
                  state_in = bcp_pkg::S_DONE;
               end else begin
                  step_in  = n_ff;
                  i_in     = '0;
                  cur_in   = w0_ff;
                  state_in = bcp_pkg::S_IRD;
               end
            end else begin
               i_in     = NW'(i_ff + 1'b1);
               state_in = bcp_pkg::S_UPM;
            end
         end
         bcp_pkg::S_UPM: begin
            prod_in  = 64'(price_ff) * 64'(up_ff) + 64'(down_ff[31:1]);
            state_in = bcp_pkg::S_UCHK;
         end
         bcp_pkg::S_UCHK: begin
            if (prod_ff[63:32] >= down_ff) begin
               price_in = 32'hFFFF_FFFF;
               sat_in   = 1'b1;
               state_in = bcp_pkg::S_PAY;
            end else begin
               rem_in   = prod_ff[63:32];
               lo_in    = prod_ff[31:0];
               div_in   = down_ff;
               cnt_in   = 5'd0;
               state_in = bcp_pkg::S_UDIV;
            end
         end
         bcp_pkg::S_UDIV: begin
            rem_in = dv_rem;
            lo_in  = dv_lo;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               price_in = dv_lo;
               state_in = bcp_pkg::S_PAY;
            end
         end
         bcp_pkg::S_IRD: begin
            state_in = bcp_pkg::S_IM1;
         end
         bcp_pkg::S_IM1: begin
            prod_in  = 64'(p_ff) * 64'(rdata_ff);
            nxt_in   = rdata_ff;
            state_in = bcp_pkg::S_IM2;
         end
         bcp_pkg::S_IM2: begin
            acc_in   = prod_ff + 64'(q_val) * 64'(cur_ff) + bcp_pkg::Q30_HALF;
            state_in = bcp_pkg::S_IM3;
         end
         bcp_pkg::S_IM3: begin
            prod_in  = 64'(mix_val) * 64'(disc_ff);
            sat_in   = sat_ff | mix_ovf;
            state_in = bcp_pkg::S_IWB;
         end
         bcp_pkg::S_IWB: begin
            mem_we    = 1'b1;
            mem_wdata = rnd_val;
            sat_in    = sat_ff | rnd_ovf;
            if (i_ff == '0) begin
               w0_in = rnd_val;
            end
            cur_in = nxt_ff;
            if (NW'(i_ff + 1'b1) == step_ff) begin
               if (step_ff == NW'(1)) begin
                  state_in = bcp_pkg::S_DONE;
               end else begin
                  step_in  = NW'(step_ff - 1'b1);
                  i_in     = '0;
                  cur_in   = w0_ff;
                  state_in = bcp_pkg::S_IRD;
               end
            end else begin
               i_in     = NW'(i_ff + 1'b1);
               state_in = bcp_pkg::S_IRD;
            end
         end
         bcp_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = w0_ff;
               rsp_status_in = inv_ff ? bcp_pkg::STATUS_INVALID :
                               (sat_ff ? bcp_pkg::STATUS_SAT : bcp_pkg::STATUS_OK);
               state_in      = bcp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bcp_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};

   // invalid factors always report a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bcp_pkg::STATUS_INVALID) |-> rsp_value_ff == 32'd0)
      else $error("invalid status with nonzero value");

   // a result appears only when leaving the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bcp_pkg::S_DONE))
      else $error("result without finished request");

   // terminal node index stays inside the tree
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcp_pkg::S_PAY) |-> i_ff <= n_ff)
      else $error("terminal node beyond period count");

   // induction never writes past the current step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcp_pkg::S_IWB) |-> (i_ff < step_ff && step_ff <= n_ff))
      else $error("induction index out of range");

endmodule

`default_nettype wire

[tb/binomial_call_pricer_tb.sv]
// binomial_call_pricer_tb: self-checking bench for the binomial call pricer
// predicts each quote from its own Q2.30 tree and checks every rsp beat in order
// depends on bcp_pkg and binomial_call_pricer
`timescale 1ns / 100ps

module binomial_call_pricer_tb;

   typedef struct packed {
      logic [31:0]         call_value;
      bcp_pkg::status_type status;
   } quote_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   logic [31:0] up_f, down_f, growth_f, disc_f;
   logic [6:0]  periods;

   quote_type   pending_quotes[$];
   int          mismatches;
   int          hold_left;
   bit          quiet;

   binomial_call_pricer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] clamp_word(input logic [63:0] v, inout bit sat);
      if (v > 64'hFFFF_FFFF) begin
         sat = 1'b1;
         return 32'hFFFF_FFFF;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] scale_q30(input logic [31:0] v, input logic [31:0] f,
                                             inout bit sat);
      logic [63:0] prod;
      prod = {32'd0, v} * {32'd0, f};
      return clamp_word((prod >> 30) + {63'd0, prod[29]}, sat);
   endfunction

   function automatic quote_type price_call(input logic [31:0] spot, input logic [31:0] strike);
      quote_type   res;
      logic [63:0] p, q, num, mix;
      logic [31:0] node;
      logic [31:0] tree[0:64];
      int          n;
      bit          sat;
      sat = 1'b0;
      if (down_f == 0 || up_f <= down_f || growth_f < down_f || growth_f > up_f) begin
         res.call_value = '0;
         res.status = bcp_pkg::STATUS_INVALID;
         return res;
      end
      n = (periods > 64) ? 64 : periods;
      p = ({32'd0, growth_f - down_f} << 30) / {32'd0, up_f - down_f};
      q = 64'h4000_0000 - p;
      node = spot;
      for (int i = 0; i < n; i++) node = scale_q30(node, down_f, sat);
      for (int i = 0; i <= n; i++) begin
         if (i > 0) begin
            num = {32'd0, node} * {32'd0, up_f} + {33'd0, down_f[31:1]};
            node = clamp_word(num / {32'd0, down_f}, sat);
         end
         tree[i] = (node > strike) ? node - strike : 32'd0;
      end
      for (int s = n; s > 0; s--)
         for (int i = 0; i < s; i++) begin
            mix = p * {32'd0, tree[i+1]} + q * {32'd0, tree[i]} + bcp_pkg::Q30_HALF;
            tree[i] = scale_q30(clamp_word(mix >> 30, sat), disc_f, sat);
         end
      res.call_value = tree[0];
      res.status = sat ? bcp_pkg::STATUS_SAT : bcp_pkg::STATUS_OK;
      return res;
   endfunction

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = value;
      case (addr)
         bcp_pkg::REG_UP:     up_f = value;
         bcp_pkg::REG_DOWN:   down_f = value;
         bcp_pkg::REG_GROWTH: growth_f = value;
         bcp_pkg::REG_DISC:   disc_f = value;
         bcp_pkg::REG_PERIOD: periods = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_tree(input logic [31:0] up, input logic [31:0] down,
                           input logic [31:0] growth, input logic [31:0] disc,
                           input logic [6:0] n);
      write_reg(bcp_pkg::REG_UP, up);
      write_reg(bcp_pkg::REG_DOWN, down);
      write_reg(bcp_pkg::REG_GROWTH, growth);
      write_reg(bcp_pkg::REG_DISC, disc);
      write_reg(bcp_pkg::REG_PERIOD, {25'd0, n});
   endtask

   task automatic send_quote(input logic [31:0] spot, input logic [31:0] strike);
      if (!quiet && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {strike, spot};
      do @(posedge clock); while (!req_tready);
      pending_quotes.push_back(price_call(spot, strike));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain;
      while (pending_quotes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // rsp side stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         hold_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      quote_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_quotes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: value %h status %0d",
                        rsp_tdata[31:0], rsp_tdata[33:32]);
         end else begin
            want = pending_quotes.pop_front();
            if (rsp_tdata[31:0] !== want.call_value || rsp_tdata[33:32] !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected %h/%0d got %h/%0d", want.call_value,
                           want.status, rsp_tdata[31:0], rsp_tdata[33:32]);
            end
         end
      end
   end

   task automatic test_reset_defaults;
      send_quote(32'h0064_0000, 32'h0064_0000);
      send_quote(32'h0000_0000, 32'h0000_0000);
      send_quote(32'hFFFF_FFFF, 32'h0000_0000);
      send_quote(32'h0000_0001, 32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_invalid_factors;
      set_tree(bcp_pkg::UP_RESET, 32'd0, bcp_pkg::GROWTH_RESET, bcp_pkg::DISC_RESET, 7'd4);
      send_quote(32'h0064_0000, 32'h0032_0000);
      drain();
      set_tree(bcp_pkg::DOWN_RESET, bcp_pkg::DOWN_RESET, bcp_pkg::DOWN_RESET,
               bcp_pkg::DISC_RESET, 7'd4);
      send_quote(32'h0064_0000, 32'h0032_0000);
      drain();
      set_tree(bcp_pkg::UP_RESET, bcp_pkg::DOWN_RESET, bcp_pkg::DOWN_RESET - 1,
               bcp_pkg::DISC_RESET, 7'd0);
      send_quote(32'h0064_0000, 32'h0032_0000);
      drain();
      set_tree(bcp_pkg::UP_RESET, bcp_pkg::DOWN_RESET, bcp_pkg::UP_RESET + 1,
               bcp_pkg::DISC_RESET, 7'd64);
      send_quote(32'hFFFF_FFFF, 32'h0000_0000);
      drain();
   endtask

   task automatic test_zero_periods;
      set_tree(bcp_pkg::UP_RESET, bcp_pkg::DOWN_RESET, bcp_pkg::GROWTH_RESET,
               bcp_pkg::DISC_RESET, 7'd0);
      send_quote(32'h0078_0000, 32'h0064_0000);
      send_quote(32'h0050_0000, 32'h0064_0000);
      send_quote(32'h0064_0000, 32'h0064_0000);
      send_quote(32'hFFFF_FFFF, 32'h0000_0000);
      drain();
   endtask

   task automatic test_saturation;
      set_tree(32'hFFFF_FFFF, 32'd1, 32'd2, 32'hFFFF_FFFF, 7'd3);
      send_quote(32'hFFFF_0000, 32'h0000_0001);
      send_quote(32'h8000_0000, 32'h0000_0000);
      drain();
      // growth at both edges of the interval
      set_tree(32'h8000_0000, 32'h2000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 7'd5);
      send_quote(32'hFFFF_FFFF, 32'h0001_0000);
      drain();
      set_tree(32'h8000_0000, 32'h2000_0000, 32'h2000_0000, 32'h0000_0000, 7'd5);
      send_quote(32'h0100_0000, 32'h0001_0000);
      drain();
   endtask

   task automatic test_period_clamp;
      set_tree(bcp_pkg::UP_RESET, bcp_pkg::DOWN_RESET, bcp_pkg::GROWTH_RESET,
               bcp_pkg::DISC_RESET, 7'd127);
      send_quote(32'h0064_0000, 32'h005A_0000);
      drain();
      write_reg(bcp_pkg::REG_PERIOD, 32'd65);
      send_quote(32'h0064_0000, 32'h006E_0000);
      drain();
   endtask

   task automatic test_random_quotes;
      logic [31:0] d, u, g, spot, strike;
      int          n, count;
      for (int r = 0; r < 10; r++) begin
         if ($urandom_range(0, 7) == 0) begin
            u = $urandom; d = $urandom; g = $urandom;
         end else if ($urandom_range(0, 1) == 0) begin
            d = $urandom_range(32'h2000_0000, 32'h3FFF_0000);
            u = $urandom_range(32'h4001_0000, 32'h6000_0000);
            g = $urandom_range(d, u);
         end else begin
            d = $urandom_range(1, 32'hFFFF_FFFE);
            u = $urandom_range(d + 1, 32'hFFFF_FFFF);
            g = $urandom_range(d, u);
         end
         n = (r == 4) ? 64 : $urandom_range(0, 6);
         if (r == 7) n = $urandom_range(65, 127);
         set_tree(u, d, g, $urandom, n[6:0]);
         count = (n > 6) ? 2 : 30;
         quiet = (r == 9);
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 1) == 0) begin
               spot = $urandom;
               strike = $urandom;
            end else begin
               spot = $urandom_range(32'h0001_0000, 32'h0200_0000);
               strike = spot + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            end
            send_quote(spot, strike);
         end
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      hold_left = 0;
      quiet = 1'b0;
      mismatches = 0;
      up_f = bcp_pkg::UP_RESET;
      down_f = bcp_pkg::DOWN_RESET;
      growth_f = bcp_pkg::GROWTH_RESET;
      disc_f = bcp_pkg::DISC_RESET;
      periods = bcp_pkg::PERIOD_RESET;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_invalid_factors();
      test_zero_periods();
      test_saturation();
      test_period_clamp();
      test_random_quotes();
      repeat (50) @(negedge clock);
      if (mismatches == 0 && pending_quotes.size() == 0) begin
         $display("binomial_call_pricer verification clean");
      end else begin
         $display("binomial_call_pricer verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("binomial_call_pricer verification failed");
      $finish;
   end

endmodule

[sim.f]
rtl/bcp_pkg.sv
rtl/binomial_call_pricer.sv
tb/binomial_call_pricer_tb.sv
